// ===== rtl/stt_pkg.sv =====
// Shared types, codes and byte classes for the script text tokenizer.
package stt_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOI  = 2'd2;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_DQ      = 3'd3;
  localparam logic [2:0] MODE_SQ      = 3'd4;
  localparam logic [2:0] MODE_ANGLE   = 3'd5;
  localparam logic [2:0] MODE_WORD    = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_SKIP_WHITE    = 3'd0;
  localparam logic [2:0] CFG_MACRO_STRINGS = 3'd1;
  localparam logic [2:0] CFG_CROSS_LINES   = 3'd2;
  localparam logic [2:0] CFG_NO_SEPARATORS = 3'd3;

  // Most results one byte can cause
  localparam int unsigned MaxResults = 4;

  // Byte constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } res_t;

  // Separator byte test, off when punctuation counts as word bytes
  function automatic logic is_sep(input logic [7:0] c, input logic no_sep);
    logic hit;
    begin
      unique case (c)
        8'h7B, 8'h7D, 8'h29, 8'h28, 8'h3A, 8'h2C, 8'h5B, 8'h5D, 8'h3B,
        8'h2B, 8'h2D, 8'h2A, CH_SLASH, 8'h25, 8'h5E, 8'h3D, CH_LT, CH_GT,
        CH_TILDE: hit = 1'b1;
        default:  hit = 1'b0;
      endcase
      is_sep = hit && !no_sep;
    end
  endfunction

endpackage

// ===== rtl/script_text_tokenizer_top.sv =====
// Script text tokenizer: byte decode, result buffer and output handshake.
// The first result of a byte is offered in the cycle after the byte is accepted. A byte
// with results holds the result buffer until the single output port has drained it; a new
// byte is taken in the cycle its last result leaves, or at once if it had no result.
// Reset: lexer idle, buffer empty, registers at skip_white=1, macro_strings=0,
// cross_lines=1, no_separators=0.
module script_text_tokenizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);
  import stt_pkg::*;

  logic skip_white_q, macro_strings_q, cross_lines_q, no_separators_q;
  logic [2:0] mode_q, mode_d;
  res_t       res_q [MaxResults];
  res_t       res_d [MaxResults];
  logic [2:0] rem_q, n_d;
  logic [1:0] pos_q;
  logic       in_acc, out_acc;

  // Between-token decode of the incoming byte
  res_t       idle_r [2];
  logic [1:0] idle_n;
  logic [2:0] idle_mode;
  // Word-continuation decode of the incoming byte
  res_t       word_r [3];
  logic [1:0] word_n;
  logic [2:0] word_mode;

  logic [7:0] c;
  logic       c_white, c_sep;

  assign c       = byte_in_i;
  assign c_white = (c <= CH_SPACE);
  assign c_sep   = is_sep(c, no_separators_q);

  // Handle a byte seen between tokens
  always_comb begin
    idle_r[0] = '0;
    idle_r[1] = '0;
    idle_n    = 2'd0;
    idle_mode = MODE_IDLE;
    if (c == CH_NUL) begin
      idle_r[0] = '{kind: KIND_EOI, value: 8'd0};
      idle_n    = 2'd1;
    end else if (c_white) begin
      if (!cross_lines_q && c == CH_NL) begin
        idle_r[0] = '{kind: KIND_END, value: 8'd0};
        idle_n    = 2'd1;
      end else if (!skip_white_q) begin
        idle_r[0] = '{kind: KIND_BYTE, value: c};
        idle_r[1] = '{kind: KIND_END, value: 8'd0};
        idle_n    = 2'd2;
      end
    end else if (c == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (c == CH_DQ || c == CH_SQ) begin
      idle_mode = (c == CH_DQ) ? MODE_DQ : MODE_SQ;
      if (!macro_strings_q) begin
        idle_r[0] = '{kind: KIND_BYTE, value: c};
        idle_n    = 2'd1;
      end
    end else if (macro_strings_q && c == CH_LT) begin
      idle_mode = MODE_ANGLE;
    end else if (c_sep) begin
      idle_r[0] = '{kind: KIND_BYTE, value: c};
      idle_r[1] = '{kind: KIND_END, value: 8'd0};
      idle_n    = 2'd2;
    end else begin
      idle_mode = MODE_WORD;
      idle_r[0] = '{kind: KIND_BYTE, value: c};
      idle_n    = 2'd1;
    end
  end

  // Handle a byte that follows a word byte
  always_comb begin
    word_r[0] = '0;
    word_r[1] = '0;
    word_r[2] = '0;
    if (c_white || c_sep) begin
      word_r[0] = '{kind: KIND_END, value: 8'd0};
      word_r[1] = idle_r[0];
      word_r[2] = idle_r[1];
      word_n    = idle_n + 2'd1;
      word_mode = idle_mode;
    end else begin
      word_r[0] = '{kind: KIND_BYTE, value: c};
      word_n    = 2'd1;
      word_mode = MODE_WORD;
    end
  end

  // Assemble the result list and next mode for the current lexer mode
  always_comb begin
    logic [7:0] q;
    for (int i = 0; i < MaxResults; i++) res_d[i] = '0;
    n_d    = 3'd0;
    mode_d = mode_q;
    q      = (mode_q == MODE_DQ) ? CH_DQ : CH_SQ;
    unique case (mode_q)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else if (!no_separators_q) begin
          res_d[0] = '{kind: KIND_BYTE, value: CH_SLASH};
          res_d[1] = '{kind: KIND_END, value: 8'd0};
          res_d[2] = idle_r[0];
          res_d[3] = idle_r[1];
          n_d      = 3'd2 + {1'b0, idle_n};
          mode_d   = idle_mode;
        end else begin
          res_d[0] = '{kind: KIND_BYTE, value: CH_SLASH};
          res_d[1] = word_r[0];
          res_d[2] = word_r[1];
          res_d[3] = word_r[2];
          n_d      = 3'd1 + {1'b0, word_n};
          mode_d   = word_mode;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL || c == CH_NUL) begin
          res_d[0] = idle_r[0];
          res_d[1] = idle_r[1];
          n_d      = {1'b0, idle_n};
          mode_d   = idle_mode;
        end
      end
      MODE_DQ, MODE_SQ: begin
        if (c == q || c == CH_NUL) begin
          mode_d = MODE_IDLE;
          if (!macro_strings_q) begin
            res_d[0] = '{kind: KIND_BYTE, value: q};
            res_d[1] = '{kind: KIND_END, value: 8'd0};
            res_d[2] = '{kind: KIND_EOI, value: 8'd0};
            n_d      = (c == CH_NUL) ? 3'd3 : 3'd2;
          end else begin
            res_d[0] = '{kind: KIND_END, value: 8'd0};
            res_d[1] = '{kind: KIND_EOI, value: 8'd0};
            n_d      = (c == CH_NUL) ? 3'd2 : 3'd1;
          end
        end else begin
          res_d[0] = '{kind: KIND_BYTE, value: c};
          n_d      = 3'd1;
        end
      end
      MODE_ANGLE: begin
        if (c == CH_GT || c == CH_NUL) begin
          mode_d   = MODE_IDLE;
          res_d[0] = '{kind: KIND_END, value: 8'd0};
          res_d[1] = '{kind: KIND_EOI, value: 8'd0};
          n_d      = (c == CH_NUL) ? 3'd2 : 3'd1;
        end else begin
          res_d[0] = '{kind: KIND_BYTE, value: c};
          n_d      = 3'd1;
        end
      end
      MODE_WORD: begin
        res_d[0] = word_r[0];
        res_d[1] = word_r[1];
        res_d[2] = word_r[2];
        n_d      = {1'b0, word_n};
        mode_d   = word_mode;
      end
      default: begin
        res_d[0] = idle_r[0];
        res_d[1] = idle_r[1];
        n_d      = {1'b0, idle_n};
        mode_d   = idle_mode;
      end
    endcase
  end

  // Handshakes: take a request when the buffer is empty or empties this cycle
  assign out_valid_o = (rem_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (rem_q > 3'd1) || ((rem_q == 3'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign kind_o  = res_q[pos_q].kind;
  assign value_o = res_q[pos_q].value;
  assign last_o  = (rem_q == 3'd1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_white_q    <= 1'b1;
      macro_strings_q <= 1'b0;
      cross_lines_q   <= 1'b1;
      no_separators_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SKIP_WHITE)    skip_white_q    <= cfg_wdata_i;
      if (cfg_index_i == CFG_MACRO_STRINGS) macro_strings_q <= cfg_wdata_i;
      if (cfg_index_i == CFG_CROSS_LINES)   cross_lines_q   <= cfg_wdata_i;
      if (cfg_index_i == CFG_NO_SEPARATORS) no_separators_q <= cfg_wdata_i;
    end
  end

  // Lexer mode and buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      rem_q  <= 3'd0;
      pos_q  <= 2'd0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      rem_q  <= n_d;
      pos_q  <= 2'd0;
    end else if (out_acc) begin
      rem_q  <= rem_q - 3'd1;
      pos_q  <= pos_q + 2'd1;
    end
  end

  // Load the result list
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxResults; i++) res_q[i] <= res_d[i];
    end
  end

  // Checks on buffer control and lexer state
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd4)
    else $error("result count above four");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (rem_q != 3'd0) |-> (rem_q == 3'd1) && out_acc)
    else $error("result buffer overwritten before drained");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_BYTE) |-> (value_o == 8'd0))
    else $error("nonzero value on end result");

  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (byte_in_i == CH_NUL) |=> (mode_q == MODE_IDLE))
    else $error("lexer not idle after end of data");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the script text tokenizer: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes = 8;
  localparam logic [2:0] TopIndex = 3'h7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } tok_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_index_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] byte_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] value_o;
  logic       last_o;

  // Token predictor state and register shadows
  logic [2:0] lex_mode = MODE_IDLE;
  logic       skip_white_r = 1'b1;
  logic       macro_str_r = 1'b0;
  logic       cross_lines_r = 1'b1;
  logic       no_sep_r = 1'b0;

  tok_res_t    step_q[$];
  tok_res_t    token_results_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          hold_off_req = 1'b0;
  string       sep_chars = "{}():,[];+-*/%^=<>~";

  script_text_tokenizer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit separator_byte(logic [7:0] c);
    if (no_sep_r) return 1'b0;
    case (c)
      "{", "}", "(", ")", ":", ",", "[", "]", ";", "+", "-", "*", CH_SLASH, "%", "^", "=",
      CH_LT, CH_GT, CH_TILDE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(logic [1:0] k, logic [7:0] v);
    tok_res_t r;
    r.kind = k;
    r.value = v;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  // Handle a byte seen between tokens
  task automatic between_tokens(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == CH_NUL) begin
      emit(KIND_EOI, 8'h00);
    end else if (c <= CH_SPACE) begin
      if (!cross_lines_r && c == CH_NL) begin
        emit(KIND_END, 8'h00);
      end else if (!skip_white_r) begin
        emit(KIND_BYTE, c);
        emit(KIND_END, 8'h00);
      end
    end else if (c == CH_SLASH) begin
      lex_mode = MODE_SLASH;
    end else if (c == CH_DQ || c == CH_SQ) begin
      if (!macro_str_r) emit(KIND_BYTE, c);
      lex_mode = (c == CH_DQ) ? MODE_DQ : MODE_SQ;
    end else if (macro_str_r && c == CH_LT) begin
      lex_mode = MODE_ANGLE;
    end else if (separator_byte(c)) begin
      emit(KIND_BYTE, c);
      emit(KIND_END, 8'h00);
    end else begin
      lex_mode = MODE_WORD;
      emit(KIND_BYTE, c);
    end
  endtask

  // Continue or close a word
  task automatic in_word(logic [7:0] c);
    if (c <= CH_SPACE || separator_byte(c)) begin
      emit(KIND_END, 8'h00);
      between_tokens(c);
    end else begin
      lex_mode = MODE_WORD;
      emit(KIND_BYTE, c);
    end
  endtask

  // Advance the predictor by one accepted byte and queue its results
  task automatic predict_byte(logic [7:0] c);
    logic [7:0] quote;
    tok_res_t   r;
    step_q.delete();
    case (lex_mode)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_COMMENT;
        end else if (!no_sep_r) begin
          emit(KIND_BYTE, CH_SLASH);
          emit(KIND_END, 8'h00);
          between_tokens(c);
        end else begin
          emit(KIND_BYTE, CH_SLASH);
          in_word(c);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL || c == CH_NUL) between_tokens(c);
      end
      MODE_DQ, MODE_SQ: begin
        quote = (lex_mode == MODE_DQ) ? CH_DQ : CH_SQ;
        if (c == quote || c == CH_NUL) begin
          if (!macro_str_r) emit(KIND_BYTE, quote);
          emit(KIND_END, 8'h00);
          lex_mode = MODE_IDLE;
          if (c == CH_NUL) emit(KIND_EOI, 8'h00);
        end else begin
          emit(KIND_BYTE, c);
        end
      end
      MODE_ANGLE: begin
        if (c == CH_GT || c == CH_NUL) begin
          emit(KIND_END, 8'h00);
          lex_mode = MODE_IDLE;
          if (c == CH_NUL) emit(KIND_EOI, 8'h00);
        end else begin
          emit(KIND_BYTE, c);
        end
      end
      MODE_WORD: in_word(c);
      default: between_tokens(c);
    endcase
    // flag the final result of this byte
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) token_results_q.push_back(step_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte, hold it until accepted, then idle for a random gap
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    byte_in_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every queued result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SKIP_WHITE:    skip_white_r = val;
      CFG_MACRO_STRINGS: macro_str_r = val;
      CFG_CROSS_LINES:   cross_lines_r = val;
      CFG_NO_SEPARATORS: no_sep_r = val;
      default: ;
    endcase
  endtask

  // Drain, then write all registers plus one unused index that must be ignored
  task automatic set_config(logic sw, logic ms, logic cl, logic ns);
    wait_drained();
    write_reg(CFG_SKIP_WHITE, sw);
    write_reg(CFG_MACRO_STRINGS, ms);
    write_reg(CFG_CROSS_LINES, cl);
    write_reg(CFG_NO_SEPARATORS, ns);
    write_reg(3'($urandom_range(CFG_NO_SEPARATORS + 1, TopIndex)), 1'($urandom_range(0, 1)));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] content_byte(logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == stop);
    return b;
  endfunction

  // Send one token with random content (a string may be left open), or a noise byte
  task automatic send_random_token();
    logic [7:0]  quote;
    int unsigned len;
    len = $urandom_range(0, 5);
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        repeat (len + 1)
          send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                                : 8'("a" + $urandom_range(0, 25)));
      end
      3: send_byte(sep_chars[$urandom_range(0, sep_chars.len() - 1)]);
      4: send_byte(8'($urandom_range(1, 32)));
      5: send_byte(CH_NL);
      6, 7: begin
        quote = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
        send_byte(quote);
        repeat (len) send_byte(content_byte(quote));
        // now and then leave the string open
        if ($urandom_range(0, 7) != 0) send_byte(quote);
      end
      8: begin
        send_byte(CH_LT);
        repeat (len) send_byte(content_byte(CH_GT));
        send_byte(CH_GT);
      end
      9: begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        repeat (len) send_byte(content_byte(CH_NL));
        send_byte(CH_NL);
      end
      10: send_byte(8'($urandom_range(0, 255)));
      default: send_byte(CH_NUL);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Words, separators, comments and an open string under reset settings
  task automatic test_default_modes();
    send_byte(8'hFF);
    send_byte("a");
    send_byte("{");
    send_byte(CH_SPACE);
    send_byte(CH_SLASH);
    send_byte("-");
    send_byte(CH_SLASH);
    send_byte(CH_SLASH);
    send_byte("z");
    send_byte(CH_NL);
    send_byte(CH_DQ);
    send_byte("q");
    send_byte(CH_NUL);
  endtask

  // Whitespace tokens, empty line token, stripped quotes, angle string left open
  task automatic test_line_and_macro_modes();
    set_config(1'b0, 1'b1, 1'b0, 1'b0);
    send_byte(8'h01);
    send_byte(CH_NL);
    send_byte(CH_SQ);
    send_byte("k");
    send_byte(CH_SQ);
    send_byte(CH_LT);
    send_byte("m");
  endtask

  // Clear macro mode inside the angle string, then slash joins a word
  task automatic test_config_mid_token();
    set_config(1'b1, 1'b0, 1'b1, 1'b1);
    send_byte(CH_GT);
    send_byte(CH_SLASH);
    send_byte("+");
    send_byte(CH_NUL);
  endtask

  // Long receiver hold-off with the sender flat out, then a full pause
  task automatic test_backpressure();
    set_config(1'b1, 1'b0, 1'b1, 1'b0);
    in_calm = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++) send_byte(sep_chars[i % sep_chars.len()]);
    wait_drained();
    in_calm = 1'b0;
    repeat (6) send_random_token();
  endtask

  task automatic test_random_text();
    int unsigned phase_end;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(1'b1, 1'b1, 1'b1, 1'b1);
        1: set_config(1'b0, 1'b0, 1'b0, 1'b0);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_token();
    end
    in_calm = 1'b0;
    out_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random output stall, with a long hold-off on request
  initial begin : result_stall_gen
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HoldOffCycles;
      end else if (stall_left == 0 && !out_stall_i) begin
        stall_left = pick_gap(out_calm);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tok_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_results_q.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h last %0b", kind_o, value_o, last_o);
        error_count++;
      end else begin
        want = token_results_q.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          error_count++;
        end
        if (value_o !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, value_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SKIP_WHITE;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    byte_in_i = CH_NUL;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_modes();
    test_line_and_macro_modes();
    test_config_mid_token();
    test_backpressure();
    test_random_text();

    wait_drained();
    if (error_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
